[sv/uqpq_pkg.sv]
// Shared types and codes of the unique-key max priority queue.
// Holds the entry record, request and status codes and the cell control word.
// No dependencies; the unit, the cell and the checker import this package.
package uqpq_pkg;

  // Most entries one list request returns
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_LIST    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] prio;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_SHIFT  = 3'd2,
    CELL_ROTATE = 3'd3,
    CELL_CLEAR  = 3'd4
  } cell_op_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_ctl_t;

endpackage

[sv/uqpq_if.sv]
// Request and response channel interfaces of the priority queue.
// Valid/ready handshake with the payload fields; no package dependency.
interface uqpq_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] priority_req;
  logic signed [31:0] key;
  logic [31:0]        payload;
  logic [5:0]         limit;

  modport source(output valid, action, priority_req, key, payload, limit, input ready);
  modport sink(input valid, action, priority_req, key, payload, limit, output ready);
endinterface

interface uqpq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] out_priority;
  logic signed [31:0] out_key;
  logic [31:0]        out_payload;
  logic               last;

  modport source(output valid, status, found, out_priority, out_key, out_payload, last,
                 input ready);
  modport sink(input valid, status, found, out_priority, out_key, out_payload, last,
               output ready);
endinterface

[sv/unique_key_max_priority_queue_unit.sv]
// Channel   | dir | handshake        | payload
// req       | in  | req.valid/ready  | action, priority_req, key, payload, limit
// rsp       | out | rsp.valid/ready  | status, found, out_priority, out_key, out_payload, last
//
// Insert, extract and clear are accepted, then take one step of the cell row.
// List is accepted, then the valid entries rotate once around the row, the
// first n of them leaving through the output register as they pass the head cell.
// Reset clears every valid bit and the count at once; no clearing pass.
// A full output register stalls the step that would write it; rotation after
// the last listed entry proceeds without the output.
module unique_key_max_priority_queue_unit
  import uqpq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  uqpq_req_if.sink    req,
  uqpq_rsp_if.source  rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $clog2(MAX_RESULTS + 1);
  localparam int NW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  state_t          state;
  action_t         req_action;
  entry_t          req_ent;
  logic [5:0]      req_limit;
  logic [CW-1:0]   count;
  logic [EW-1:0]   emit_left;
  logic [CW-1:0]   rot_left;

  logic            rsp_valid_q;
  status_t         status_q;
  logic            found_q;
  entry_t          out_q;
  logic            last_q;

  cell_ctl_t       ctl;
  entry_t          cell_ent [DEPTH];
  logic [DEPTH-1:0] cell_vld;
  logic [DEPTH-1:0] cell_keep;
  logic [DEPTH-1:0] cell_match;

  logic            out_free;
  logic            exec_go;
  logic            list_go;
  logic            rsp_load;
  logic            dup;
  logic            full;
  logic [NW-1:0]   lim_w;
  logic [NW-1:0]   cnt_w;
  logic [NW-1:0]   n_w;
  logic [EW-1:0]   n_list;

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid_q;
  assign rsp.status       = status_q;
  assign rsp.found        = found_q;
  assign rsp.out_priority = out_q.prio;
  assign rsp.out_key      = out_q.key;
  assign rsp.out_payload  = out_q.payload;
  assign rsp.last         = last_q;

  assign out_free = !rsp_valid_q || rsp.ready;
  assign exec_go  = (state == S_EXEC) && out_free;
  assign list_go  = (state == S_LIST) && ((emit_left == '0) || out_free);
  assign dup      = |cell_match;
  assign full     = (count == CW'(DEPTH));

  // Load the output register on every step that produces a response
  assign rsp_load = (exec_go && !((req_action == ACT_LIST) && (count != '0))) ||
                    (list_go && (emit_left != '0));

  // Saturate the list length to the count and to the result limit
  always_comb begin
    lim_w = NW'(req_limit);
    cnt_w = NW'(count);
    n_w   = ((lim_w == '0) || (lim_w > cnt_w)) ? cnt_w : lim_w;
    if (n_w > NW'(MAX_RESULTS)) begin
      n_w = NW'(MAX_RESULTS);
    end
    n_list = EW'(n_w);
  end

  // Drive the broadcast step for the cell row
  always_comb begin
    ctl.ent = req_ent;
    ctl.op  = CELL_HOLD;
    if (exec_go) begin
      case (req_action)
        ACT_INSERT:  ctl.op = (!dup && !full) ? CELL_INSERT : CELL_HOLD;
        ACT_EXTRACT: ctl.op = (count != '0) ? CELL_SHIFT : CELL_HOLD;
        ACT_CLEAR:   ctl.op = CELL_CLEAR;
        default:     ctl.op = CELL_HOLD;
      endcase
    end else if (list_go) begin
      ctl.op = CELL_ROTATE;
    end
  end

  // Sorted row of cells, best entry in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_keep;
    entry_t prev_ent;
    logic   prev_vld;
    entry_t next_ent;
    logic   next_vld;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign prev_ent  = req_ent;
      assign prev_vld  = 1'b0;
    end else begin : g_mid
      assign prev_keep = cell_keep[i-1];
      assign prev_ent  = cell_ent[i-1];
      assign prev_vld  = cell_vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_ent = cell_ent[i];
      assign next_vld = 1'b0;
    end else begin : g_inner
      assign next_ent = cell_ent[i+1];
      assign next_vld = cell_vld[i+1];
    end

    uqpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev_keep (prev_keep),
      .prev_ent  (prev_ent),
      .prev_vld  (prev_vld),
      .next_ent  (next_ent),
      .next_vld  (next_vld),
      .head_ent  (cell_ent[0]),
      .ent       (cell_ent[i]),
      .vld       (cell_vld[i]),
      .keep      (cell_keep[i]),
      .match     (cell_match[i])
    );
  end

  // Sequence requests and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      emit_left   <= '0;
      rot_left    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp.ready);
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_action  <= action_t'(req.action);
            req_ent     <= '{prio: req.priority_req, key: req.key, payload: req.payload};
            req_limit   <= req.limit;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            case (req_action)
              ACT_INSERT: begin
                status_q <= dup ? ST_DUP : (full ? ST_FULL : ST_OK);
                found_q  <= 1'b0;
                out_q    <= '0;
                last_q   <= 1'b1;
                state    <= S_IDLE;
                if (!dup && !full) begin
                  count <= count + CW'(1);
                end
              end
              ACT_EXTRACT: begin
                last_q <= 1'b1;
                state  <= S_IDLE;
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  found_q  <= 1'b0;
                  out_q    <= '0;
                end else begin
                  status_q <= ST_OK;
                  found_q  <= 1'b1;
                  out_q    <= cell_ent[0];
                  count    <= count - CW'(1);
                end
              end
              ACT_LIST: begin
                if (count == '0) begin
                  status_q <= ST_EMPTY;
                  found_q  <= 1'b0;
                  out_q    <= '0;
                  last_q   <= 1'b1;
                  state    <= S_IDLE;
                end else begin
                  emit_left <= n_list;
                  rot_left  <= count;
                  state     <= S_LIST;
                end
              end
              ACT_CLEAR: begin
                status_q <= ST_OK;
                found_q  <= 1'b0;
                out_q    <= '0;
                last_q   <= 1'b1;
                count    <= '0;
                state    <= S_IDLE;
              end
              default: begin
                status_q <= ST_OK;
                found_q  <= 1'b0;
                out_q    <= '0;
                last_q   <= 1'b1;
                state    <= S_IDLE;
              end
            endcase
          end
        end
        S_LIST: begin
          if (list_go) begin
            if (emit_left != '0) begin
              status_q    <= ST_OK;
              found_q     <= 1'b1;
              out_q       <= cell_ent[0];
              last_q      <= (emit_left == EW'(1));
              emit_left   <= emit_left - EW'(1);
            end
            rot_left <= rot_left - CW'(1);
            if (rot_left == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/uqpq_cell.sv]
// One slot of the sorted entry row: holds an entry and its valid bit.
// Depends on uqpq_pkg for entry_t and the cell control word.
module uqpq_cell
  import uqpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      prev_keep,
  input  entry_t    prev_ent,
  input  logic      prev_vld,
  input  entry_t    next_ent,
  input  logic      next_vld,
  input  entry_t    head_ent,
  output entry_t    ent,
  output logic      vld,
  output logic      keep,
  output logic      match
);

  entry_t ent_next;
  logic   vld_next;

  // Compare this slot against the broadcast entry
  assign keep  = vld && ($signed(ent.prio) >= $signed(ctl.ent.prio));
  assign match = vld && (ent.key == ctl.ent.key);

  // Pick the next contents from self, neighbors or the broadcast entry
  always_comb begin
    ent_next = ent;
    vld_next = vld;
    case (ctl.op)
      CELL_INSERT: begin
        if (!keep) begin
          if (prev_keep) begin
            ent_next = ctl.ent;
            vld_next = 1'b1;
          end else begin
            ent_next = prev_ent;
            vld_next = prev_vld;
          end
        end
      end
      CELL_SHIFT: begin
        ent_next = next_ent;
        vld_next = next_vld;
      end
      CELL_ROTATE: begin
        ent_next = (vld && !next_vld) ? head_ent : next_ent;
      end
      CELL_CLEAR: begin
        vld_next = 1'b0;
      end
      default: begin
        ent_next = ent;
        vld_next = vld;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

[sv/uqpq_checker.sv]
// Port-level checks of the priority queue top level, attached by bind.
// Depends on uqpq_pkg for the status codes and on the top level's ports.
module uqpq_checker
  import uqpq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         rsp_status,
  input logic               rsp_found,
  input logic signed [31:0] rsp_out_priority,
  input logic signed [31:0] rsp_out_key,
  input logic [31:0]        rsp_out_payload,
  input logic               rsp_last
);

  // A stalled response holds its valid, its key and its status
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_key) && $stable(rsp_status))
    else $error("stalled response changed");

  // One request at a time: ready drops after an accepted request
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // Only an ok response carries an entry
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_status == ST_OK)
    else $error("entry returned with non-ok status");

  // Error responses are single and final
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_last && !rsp_found)
    else $error("error response not final");

  // Entryless responses show zero fields and are final
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |->
      rsp_out_priority == 0 && rsp_out_key == 0 && rsp_out_payload == 0 && rsp_last)
    else $error("entryless response with nonzero fields");

endmodule

bind unique_key_max_priority_queue_unit uqpq_checker u_uqpq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_found        (rsp.found),
  .rsp_out_priority (rsp.out_priority),
  .rsp_out_key      (rsp.out_key),
  .rsp_out_payload  (rsp.out_payload),
  .rsp_last         (rsp.last)
);
